// File: design/lort_pkg.sv
// Shared types, codes and defaults for the lidar occupancy ray tracer.
`timescale 1ns / 1ps

package lort_pkg;

    // Default grid size
    localparam int GRID_W_DEF = 256;
    localparam int GRID_H_DEF = 256;

    // Field widths
    localparam int COORD_W    = 24;
    localparam int RANGE_W    = 47;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 47;

    // Request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_POINT = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Cell states
    localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [1:0] CELL_FREE     = 2'd1;
    localparam logic [1:0] CELL_OCCUPIED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE_SQ = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_CHECK,
        ST_TRACE,
        ST_MARK,
        ST_READ,
        ST_FETCH,
        ST_DONE
    } lort_state_t;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [7:0]                read_col;
        logic [7:0]                read_row;
    } in_item_t;

    typedef struct packed {
        logic [1:0] cell_state;
        logic       point_kept;
    } out_item_t;

endpackage

// File: design/lidar_occupancy_ray_tracer.sv
// Occupancy grid ray tracer: point filter, line walk and grid memory.
`timescale 1ns / 1ps

// Request paths to m_valid: a read runs READ and FETCH, an unknown request goes straight to DONE,
// a point runs MUL_X, MUL_Y and CHECK, and a kept point then walks the N cells on its ray in TRACE
// (N = max(|dx|,|dy|) + 1, at most about GRID_W/2 + 1) and marks its end in MARK; all end in DONE.
// A clear writes all 2^(clog2(GRID_W)+clog2(GRID_H)) entries, one entry per cycle. One item in flight:
// s_ready rises as the result register loads; a result still in the output register holds the load.
// Reset: a clearing pass over all 2^(clog2(GRID_W)+clog2(GRID_H)) entries runs first; s_ready stays low.
module lidar_occupancy_ray_tracer #(
    parameter int GRID_W = lort_pkg::GRID_W_DEF,
    parameter int GRID_H = lort_pkg::GRID_H_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lort_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lort_pkg::out_item_t                 m_item,
    input  logic                                cfg_wr_en,
    input  logic [lort_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lort_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lort_pkg::*;

    // Grid geometry: address is {row, col}
    localparam int CW    = $clog2(GRID_W);
    localparam int RW    = $clog2(GRID_H);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int MW    = (CW > RW) ? CW : RW;
    localparam int SW    = MW + 3;

    localparam logic [CW-1:0] X0 = CW'(GRID_W / 2);
    localparam logic [RW-1:0] Y0 = RW'(GRID_H / 2);

    // Half-grid offset in 8-bit fixed point, and the exclusive cell limits
    localparam logic signed [25:0] OFFS_X = 26'(GRID_W * 128);
    localparam logic signed [25:0] OFFS_Y = 26'(GRID_H * 128);
    localparam logic [17:0]        LIM_X  = 18'(GRID_W);
    localparam logic [17:0]        LIM_Y  = 18'(GRID_H);

    // Map one coordinate to a cell: {inside, cell}, truncating toward zero
    function automatic logic [18:0] to_cell(input logic signed [23:0] coord,
                                            input logic signed [25:0] offs,
                                            input logic [17:0] lim);
        logic signed [25:0] v;
        logic [17:0]        c;
        logic               ok;
        v  = $signed({{2{coord[23]}}, coord}) + offs;
        ok = (v > -26'sd256);
        c  = v[25] ? 18'd0 : v[25:8];
        ok = ok && (c < lim);
        return {ok, c};
    endfunction

    // Grid memory
    logic [1:0]    grid_mem [0:DEPTH-1];
    logic [1:0]    rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_data;

    // Control
    lort_state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clr_resp_reg, clr_resp_next;

    // Configuration
    logic signed [COORD_W-1:0] min_h_reg, min_h_next;
    logic signed [COORD_W-1:0] max_h_reg, max_h_next;
    logic [RANGE_W-1:0]        range_reg, range_next;

    // Latched item
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic signed [COORD_W-1:0] pz_reg, pz_next;
    logic [7:0]                rcol_reg, rcol_next;
    logic [7:0]                rrow_reg, rrow_next;

    // Filter
    logic [RANGE_W-1:0] sqx_reg, sqx_next;
    logic [RANGE_W-1:0] sqy_reg, sqy_next;
    logic               zok_reg, zok_next;
    logic               cell_ok_reg, cell_ok_next;
    logic [CW-1:0]      ex_reg, ex_next;
    logic [RW-1:0]      ey_reg, ey_next;

    // Line walk
    logic [CW-1:0]        cx_reg, cx_next;
    logic [RW-1:0]        cy_reg, cy_next;
    logic signed [SW-1:0] dx_reg, dx_next;
    logic signed [SW-1:0] dy_reg, dy_next;
    logic signed [SW-1:0] err_reg, err_next;
    logic                 sx_neg_reg, sx_neg_next;
    logic                 sy_neg_reg, sy_neg_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;

    // Result
    logic [1:0] res_cell_reg, res_cell_next;
    logic       res_kept_reg, res_kept_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_item_reg, m_item_next;

    // Shared squaring unit and helpers
    logic signed [COORD_W-1:0]   mul_op;
    logic signed [2*COORD_W-1:0] mul_prod;
    logic [18:0]                 cell_x, cell_y;
    logic [RANGE_W:0]            r2;
    logic signed [SW-1:0]        ex_s, ey_s, x0_s, y0_s;
    logic signed [SW:0]          e2, dx_w, dy_w;
    logic                        step_x, step_y;
    logic [15:0]                 col_wide, row_wide;
    logic                        rd_inside;

    assign mul_op   = (state_reg == ST_MUL_X) ? px_reg : py_reg;
    assign mul_prod = mul_op * mul_op;

    assign cell_x = to_cell(px_reg, OFFS_X, LIM_X);
    assign cell_y = to_cell(py_reg, OFFS_Y, LIM_Y);

    assign r2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    assign ex_s = $signed({{(SW-CW){1'b0}}, ex_reg});
    assign ey_s = $signed({{(SW-RW){1'b0}}, ey_reg});
    assign x0_s = $signed({{(SW-CW){1'b0}}, X0});
    assign y0_s = $signed({{(SW-RW){1'b0}}, Y0});

    assign e2     = {err_reg, 1'b0};
    assign dx_w   = {dx_reg[SW-1], dx_reg};
    assign dy_w   = {dy_reg[SW-1], dy_reg};
    assign step_x = (e2 > -dy_w);
    assign step_y = (e2 < dx_w);

    assign col_wide  = {8'h00, rcol_reg};
    assign row_wide  = {8'h00, rrow_reg};
    assign rd_inside = (col_wide < 16'(GRID_W)) && (row_wide < 16'(GRID_H));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Grid memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // Sequencer and datapath
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_resp_next  = clr_resp_reg;
        min_h_next     = min_h_reg;
        max_h_next     = max_h_reg;
        range_next     = range_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;
        rcol_next      = rcol_reg;
        rrow_next      = rrow_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        zok_next       = zok_reg;
        cell_ok_next   = cell_ok_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        err_next       = err_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        res_cell_next  = res_cell_reg;
        res_kept_next  = res_kept_reg;
        m_valid_next   = m_valid_reg;
        m_item_next    = m_item_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = CELL_UNKNOWN;

        // Configuration writes are taken in any state
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MIN_HEIGHT:   min_h_next = $signed(cfg_wdata[COORD_W-1:0]);
                CFG_MAX_HEIGHT:   max_h_next = $signed(cfg_wdata[COORD_W-1:0]);
                CFG_MAX_RANGE_SQ: range_next = cfg_wdata[RANGE_W-1:0];
                default:          ;
            endcase
        end

        // Drop the result once its transfer completes
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Write back the cell read in the previous walk cycle: unknown turns free
        if (pend_reg && (rd_data_reg == CELL_UNKNOWN)) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = CELL_FREE;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = CELL_UNKNOWN;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1) begin
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    px_next       = s_item.point_x;
                    py_next       = s_item.point_y;
                    pz_next       = s_item.point_z;
                    rcol_next     = s_item.read_col;
                    rrow_next     = s_item.read_row;
                    res_cell_next = CELL_UNKNOWN;
                    res_kept_next = 1'b0;
                    unique case (s_item.req_type)
                        REQ_CLEAR: begin
                            clr_cnt_next  = '0;
                            clr_resp_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        REQ_POINT: state_next = ST_MUL_X;
                        REQ_READ:  state_next = ST_READ;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_MUL_X: begin
                sqx_next     = mul_prod[RANGE_W-1:0];
                zok_next     = (pz_reg >= min_h_reg) && (pz_reg <= max_h_reg);
                cell_ok_next = cell_x[18] && cell_y[18];
                ex_next      = cell_x[CW-1:0];
                ey_next      = cell_y[RW-1:0];
                state_next   = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                sqy_next   = mul_prod[RANGE_W-1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (zok_reg && cell_ok_reg && (r2 <= {1'b0, range_reg})) begin
                    res_kept_next = 1'b1;
                    cx_next       = X0;
                    cy_next       = Y0;
                    dx_next       = (ex_s > x0_s) ? (ex_s - x0_s) : (x0_s - ex_s);
                    dy_next       = (ey_s > y0_s) ? (ey_s - y0_s) : (y0_s - ey_s);
                    err_next      = ((ex_s > x0_s) ? (ex_s - x0_s) : (x0_s - ex_s))
                                  - ((ey_s > y0_s) ? (ey_s - y0_s) : (y0_s - ey_s));
                    sx_neg_next   = !(x0_s < ex_s);
                    sy_neg_next   = !(y0_s < ey_s);
                    state_next    = ST_TRACE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_TRACE: begin
                // Issue the read of the current cell, then advance one step or, at the end cell, go to MARK
                rd_en   = 1'b1;
                rd_addr = {cy_reg, cx_reg};
                if ((cx_reg == ex_reg) && (cy_reg == ey_reg)) begin
                    state_next = ST_MARK;
                end else begin
                    pend_next      = 1'b1;
                    pend_addr_next = {cy_reg, cx_reg};
                    err_next       = err_reg - (step_x ? dy_reg : '0)
                                             + (step_y ? dx_reg : '0);
                    if (step_x) begin
                        cx_next = sx_neg_reg ? (cx_reg - CW'(1)) : (cx_reg + CW'(1));
                    end
                    if (step_y) begin
                        cy_next = sy_neg_reg ? (cy_reg - RW'(1)) : (cy_reg + RW'(1));
                    end
                end
            end
            ST_MARK: begin
                wr_en      = 1'b1;
                wr_addr    = {ey_reg, ex_reg};
                wr_data    = CELL_OCCUPIED;
                state_next = ST_DONE;
            end
            ST_READ: begin
                rd_en      = 1'b1;
                rd_addr    = {row_wide[RW-1:0], col_wide[CW-1:0]};
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                res_cell_next = rd_inside ? rd_data_reg : CELL_UNKNOWN;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                // Hand over once the output register is free or emptying
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_item_next.cell_state = res_cell_reg;
                    m_item_next.point_kept = res_kept_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            min_h_reg    <= 24'sh800000;
            max_h_reg    <= 24'sd8388607;
            range_reg    <= '1;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_resp_reg <= clr_resp_next;
            min_h_reg    <= min_h_next;
            max_h_reg    <= max_h_next;
            range_reg    <= range_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        pz_reg        <= pz_next;
        rcol_reg      <= rcol_next;
        rrow_reg      <= rrow_next;
        sqx_reg       <= sqx_next;
        sqy_reg       <= sqy_next;
        zok_reg       <= zok_next;
        cell_ok_reg   <= cell_ok_next;
        ex_reg        <= ex_next;
        ey_reg        <= ey_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        err_reg       <= err_next;
        sx_neg_reg    <= sx_neg_next;
        sy_neg_reg    <= sy_neg_next;
        pend_addr_reg <= pend_addr_next;
        res_cell_reg  <= res_cell_next;
        res_kept_reg  <= res_kept_next;
        m_item_reg    <= m_item_next;
    end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the lidar occupancy ray tracer: stimulus, shadow grid and checks.
`timescale 1ns / 1ps

module tb_top;
    import lort_pkg::*;

    localparam int GW = GRID_W_DEF;
    localparam int GH = GRID_H_DEF;

    // Codes the package leaves unnamed: the spare request type and register slot
    localparam logic [1:0]           REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint RANGE_TOP = (longint'(1) << RANGE_W) - 1;
    localparam int     Z_LOWEST  = -8388608;
    localparam int     Z_HIGHEST = 8388607;

    // A clear walks the whole grid; allow three of them before declaring a hang
    localparam int STALL_LIMIT  = 3 * GW * GH + 1000;
    // Longest ray plus filtering and the output register, with margin
    localparam int DRAIN_CYCLES = GW + 64;

    typedef struct {
        int col;
        int row;
    } spot_t;

    // Shadow copy of the grid and the filter registers; predicts one report per transfer
    class occupancy_shadow;
        bit [1:0]    grid_map [GW*GH];
        longint      floor_z;
        longint      ceil_z;
        longint      reach_sq;
        out_item_t   due_reports [$];
        int unsigned mismatches;

        function new();
            floor_z  = Z_LOWEST;
            ceil_z   = Z_HIGHEST;
            reach_sq = RANGE_TOP;
            mismatches = 0;
            wipe_grid();
        endfunction

        function void wipe_grid();
            foreach (grid_map[i]) grid_map[i] = CELL_UNKNOWN;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_HEIGHT:   floor_z  = $signed(data[COORD_W-1:0]);
                CFG_MAX_HEIGHT:   ceil_z   = $signed(data[COORD_W-1:0]);
                CFG_MAX_RANGE_SQ: reach_sq = longint'(data[RANGE_W-1:0]);
                default: ;
            endcase
        endfunction

        // Cell along one axis after the half-grid offset, truncated toward zero; -1 if outside
        function int axis_cell(longint coord, int size);
            longint v;
            v = coord + longint'(size) * 128;
            if (v <= -256) return -1;
            if (v < 0) return 0;
            if ((v >>> 8) >= size) return -1;
            return int'(v >>> 8);
        endfunction

        function void free_if_unknown(int cx, int cy);
            if (cx >= 0 && cx < GW && cy >= 0 && cy < GH) begin
                if (grid_map[cy*GW + cx] == CELL_UNKNOWN) grid_map[cy*GW + cx] = CELL_FREE;
            end
        endfunction

        // Bresenham walk from the centre cell to the end cell
        function void trace_ray(int x1, int y1);
            int dx, dy, step_x, step_y, err, e2, cx, cy;
            cx = GW / 2;
            cy = GH / 2;
            dx = (x1 > cx) ? x1 - cx : cx - x1;
            dy = (y1 > cy) ? y1 - cy : cy - y1;
            step_x = (cx < x1) ? 1 : -1;
            step_y = (cy < y1) ? 1 : -1;
            err = dx - dy;
            free_if_unknown(cx, cy);
            while (cx != x1 || cy != y1) begin
                e2 = 2 * err;
                if (e2 > -dy) begin
                    err -= dy;
                    cx += step_x;
                end
                if (e2 < dx) begin
                    err += dx;
                    cy += step_y;
                end
                free_if_unknown(cx, cy);
            end
        endfunction

        function void take_request(in_item_t req);
            out_item_t want;
            longint    x, y, z, r2;
            int        ex, ey;
            want = '0;
            case (req.req_type)
                REQ_CLEAR: wipe_grid();
                REQ_POINT: begin
                    x = $signed(req.point_x);
                    y = $signed(req.point_y);
                    z = $signed(req.point_z);
                    r2 = x * x + y * y;
                    if (z >= floor_z && z <= ceil_z && r2 <= reach_sq) begin
                        ex = axis_cell(x, GW);
                        ey = axis_cell(y, GH);
                        if (ex >= 0 && ey >= 0) begin
                            trace_ray(ex, ey);
                            grid_map[ey*GW + ex] = CELL_OCCUPIED;
                            want.point_kept = 1'b1;
                        end
                    end
                end
                REQ_READ: begin
                    if (req.read_col < GW && req.read_row < GH)
                        want.cell_state = grid_map[int'(req.read_row)*GW + int'(req.read_col)];
                end
                default: ;
            endcase
            due_reports.insert(due_reports.size(), want);
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (due_reports.size() == 0) begin
                $display("%0t: report with none due: cell_state %0d point_kept %0d",
                         $time, got.cell_state, got.point_kept);
                mismatches++;
                return;
            end
            want = due_reports.pop_front();
            if (got.cell_state !== want.cell_state) begin
                $display("%0t: cell_state expected %0d, got %0d",
                         $time, want.cell_state, got.cell_state);
                mismatches++;
            end
            if (got.point_kept !== want.point_kept) begin
                $display("%0t: point_kept expected %0d, got %0d",
                         $time, want.point_kept, got.point_kept);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    occupancy_shadow shadow;
    spot_t           recent_spots [$];   // end cells of recent rays, aimed at by reads
    int              cur_lo;             // height window as currently programmed
    int              cur_hi;
    bit              gaps_on;            // allow idle bursts on both channels
    int              stall_left;
    int              quiet_cycles;

    lidar_occupancy_ray_tracer #(
        .GRID_W(GW),
        .GRID_H(GH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: drop ready in bursts while gaps are allowed
    initial begin
        m_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                stall_left = int'($urandom_range(1, 8)) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Check every result transfer against the oldest due report
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) shadow.check_report(m_item);
    end

    // Watchdog: count cycles without any transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Coordinate, 8 fraction bits, of the lower edge of a cell
    function automatic int at_cell(int c);
        return (c - GW / 2) * 256;
    endfunction

    // Every field random; callers overwrite what matters
    function automatic in_item_t noise_item();
        in_item_t req;
        req.req_type = 2'($urandom);
        req.point_x  = COORD_W'($urandom);
        req.point_y  = COORD_W'($urandom);
        req.point_z  = COORD_W'($urandom);
        req.read_col = 8'($urandom);
        req.read_row = 8'($urandom);
        return req;
    endfunction

    function automatic in_item_t point_req(int x, int y, int z);
        in_item_t req;
        req = noise_item();
        req.req_type = REQ_POINT;
        req.point_x = COORD_W'(x);
        req.point_y = COORD_W'(y);
        req.point_z = COORD_W'(z);
        return req;
    endfunction

    function automatic in_item_t read_req(int col, int row);
        in_item_t req;
        req = noise_item();
        req.req_type = REQ_READ;
        req.read_col = 8'(col);
        req.read_row = 8'(row);
        return req;
    endfunction

    function automatic in_item_t plain_req(logic [1:0] code);
        in_item_t req;
        req = noise_item();
        req.req_type = code;
        return req;
    endfunction

    // Height: mostly inside the programmed window, with its edges and just beyond
    function automatic int pick_height();
        logic signed [COORD_W-1:0] raw;
        int pick;
        raw = COORD_W'($urandom);
        pick = $urandom_range(0, 9);
        if (cur_lo > cur_hi || pick == 0) return int'(raw);
        if (pick == 1) return cur_lo;
        if (pick == 2) return cur_hi;
        if (pick == 3) return $urandom_range(0, 1) ? cur_lo - 1 : cur_hi + 1;
        return cur_lo + int'($urandom_range(0, cur_hi - cur_lo));
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        spot_t    s;
        int       pick, c, r, x, y;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            // aimed ray: end cell chosen first, a few just outside the grid
            c = $urandom_range(0, GW + 7);
            r = $urandom_range(0, GH + 7);
            c -= 4;
            r -= 4;
            req = point_req(at_cell(c) + $urandom_range(0, 255),
                            at_cell(r) + $urandom_range(0, 255), pick_height());
            if (c >= 0 && c < GW && r >= 0 && r < GH) begin
                s.col = c;
                s.row = r;
                recent_spots.insert(recent_spots.size(), s);
                if (recent_spots.size() > 24) void'(recent_spots.pop_front());
            end
        end else if (pick < 56) begin
            req = plain_req(REQ_POINT);
        end else if (pick < 60) begin
            // around the grid border and the slightly-negative band
            x = $urandom_range(0, 600);
            x += ($urandom_range(0, 1) ? at_cell(GW) : at_cell(0)) - 300;
            y = $urandom_range(0, 2000);
            y -= 1000;
            if ($urandom_range(0, 1)) req = point_req(x, y, pick_height());
            else req = point_req(y, x, pick_height());
        end else if (pick < 90) begin
            req = plain_req(REQ_READ);
            if (recent_spots.size() != 0 && $urandom_range(0, 2) != 0) begin
                s = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
                case ($urandom_range(0, 2))
                    0: ;
                    1: begin
                        s.col = (s.col + GW / 2) / 2;
                        s.row = (s.row + GH / 2) / 2;
                    end
                    default: begin
                        c = $urandom_range(0, 2);
                        r = $urandom_range(0, 2);
                        s.col += c - 1;
                        s.row += r - 1;
                    end
                endcase
                req.read_col = 8'(s.col);
                req.read_row = 8'(s.row);
            end
        end else if (pick < 93) begin
            req = plain_req(REQ_UNUSED);
        end else begin
            // right next to the sensor, so a zero range limit still keeps some
            x = $urandom_range(0, 2);
            y = $urandom_range(0, 2);
            req = point_req(x - 1, y - 1, pick_height());
        end
        return req;
    endfunction

    // Present one request, optionally after an idle burst, and hold it until the transfer
    task automatic send_request(in_item_t req);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 9) < 3) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_item = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        shadow.take_request(req);
    endtask

    // Drop valid and wait for every due report; the block is then idle
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (shadow.due_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        shadow.write_register(idx, data);
    endtask

    task automatic set_limits(int lo, int hi, longint reach);
        write_register(CFG_MIN_HEIGHT, CFG_DATA_W'(lo));
        write_register(CFG_MAX_HEIGHT, CFG_DATA_W'(hi));
        write_register(CFG_MAX_RANGE_SQ, CFG_DATA_W'(reach));
        cur_lo = lo;
        cur_hi = hi;
    endtask

    task automatic run_random(int count);
        repeat (count) send_request(random_request());
        settle();
    endtask

    initial begin
        shadow = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cur_lo = Z_LOWEST;
        cur_hi = Z_HIGHEST;
        gaps_on = 1'b1;
        quiet_cycles = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at reset limits; the first transfer waits out the clearing pass
        send_request(read_req(GW / 2, GH / 2));                       // untouched centre
        send_request(point_req(0, 0, 0));                             // zero-length ray
        send_request(read_req(GW / 2, GH / 2));
        send_request(point_req(at_cell(GW - 1) + 255, 0, Z_HIGHEST)); // last column, top z
        send_request(read_req(200, GH / 2));
        send_request(read_req(GW - 1, GH / 2));
        // x just below cell 0 truncates into it; y exactly on its lower edge
        send_request(point_req(at_cell(0) - 1, at_cell(0), Z_LOWEST));
        send_request(read_req(0, 0));
        send_request(read_req(64, 64));
        send_request(point_req(at_cell(0) - 256, 0, 0));              // one whole cell short
        send_request(point_req(at_cell(GW), 0, 0));                   // one past the edge
        send_request(point_req(Z_LOWEST, Z_LOWEST, 0));               // range just over the top
        send_request(point_req(Z_HIGHEST, Z_HIGHEST, 0));             // in range, off grid
        send_request(point_req(0, at_cell(GH - 1) + 255, 0));         // ray over an occupied cell
        send_request(read_req(GW / 2, GH / 2));
        send_request(point_req(at_cell(230), 0, 0));
        send_request(point_req(at_cell(GW - 1), 0, 0));               // must not free it again
        send_request(read_req(230, GH / 2));
        send_request(point_req(at_cell(140), at_cell(20), 0));        // steep ray
        send_request(read_req(134, 74));
        send_request(plain_req(REQ_UNUSED));
        send_request(read_req(GW - 1, 0));
        send_request(plain_req(REQ_CLEAR));
        send_request(read_req(GW - 1, GH / 2));
        settle();

        // Spare register slot must be ignored; then the widest limits
        write_register(CFG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
        set_limits(Z_LOWEST, Z_HIGHEST, RANGE_TOP);
        run_random(150);

        // Narrow height band and a 100-cell radius on a fresh scan
        send_request(plain_req(REQ_CLEAR));
        settle();
        set_limits(-256, 512, longint'(100 * 256) * (100 * 256));
        run_random(150);

        // Inverted height limits: nothing is kept
        set_limits(1000, -1000, RANGE_TOP);
        run_random(60);

        // Zero range and a single height, with no idling on either side
        gaps_on = 1'b0;
        set_limits(0, 0, 0);
        run_random(60);

        gaps_on = 1'b1;
        set_limits(0, Z_HIGHEST, longint'(60 * 256) * (60 * 256));
        run_random(150);

        // Final stretch: new scan, widest limits, back-to-back transfers
        send_request(plain_req(REQ_CLEAR));
        settle();
        gaps_on = 1'b0;
        set_limits(Z_LOWEST, Z_HIGHEST, RANGE_TOP);
        run_random(300);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.due_reports.size() != 0) begin
            $display("%0t: %0d reports never arrived", $time, shadow.due_reports.size());
            shadow.mismatches++;
        end
        if (shadow.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/lort_pkg.sv
design/lidar_occupancy_ray_tracer.sv
sim/tb_top.sv
